/* rtl/csct_pkg.sv */
// Package for the CSC transpose core: constants, action codes, item structs
// and controller/datapath command and status types. No dependencies.
package csct_pkg;

  localparam int unsigned MaxRows  = 1024;
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned CntW     = 17;
  localparam logic [CntW-1:0] NnzCap = 17'd65536;

  typedef enum logic [2:0] {
    ACT_START    = 3'd0,
    ACT_COUNT    = 3'd1,
    ACT_FINALIZE = 3'd2,
    ACT_PLACE    = 3'd3,
    ACT_READ     = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] slot;
    logic [9:0]  out_col;
    logic [63:0] out_value;
    logic [16:0] pointer;
    logic        error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_RMW,
    ST_RESP,
    ST_INIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_idx;   // index and sum := 0
    logic clr_wr;    // write zero at index, advance
    logic fin_rd;    // read counter at index
    logic fin_wr;    // write prefix, advance
    logic rd_item;   // read memories at item row
    logic finish;    // build result (RMW write too)
    logic out_take;  // result consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       idx_last;  // index reached the last row in use
    logic       clr_last;  // index reached the last counter
    logic       out_full;
  } sts_t;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] a, logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, NnzCap}) ? NnzCap : s[CntW-1:0];
  endfunction

endpackage

/* rtl/csct_datapath.sv */
// Datapath of the CSC transpose core: counter/start memories, prefix sum,
// item and result registers. Depends on csct_pkg.
module csct_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csct_pkg::in_item_t  in_item_i,
  input  logic [10:0]         num_rows_i,
  input  csct_pkg::cmd_t      cmd_i,
  output csct_pkg::sts_t      sts_o,
  output csct_pkg::out_item_t out_item_o
);
  import csct_pkg::*;

  logic [CntW-1:0] cnt_mem [MaxRows];
  logic [CntW-1:0] start_mem [MaxRows];

  in_item_t        item_q;
  logic [RowW:0]   idx_q;
  logic [CntW-1:0] sum_q, cnt_rd_q, start_rd_q;
  logic            out_full_q;
  out_item_t       out_q;
  logic [RowW:0]   lim;
  logic            row_bad;
  logic [CntW-1:0] inc;

  assign lim     = (num_rows_i > 11'(MaxRows)) ? (RowW+1)'(MaxRows) : num_rows_i[RowW:0];
  assign row_bad = {1'b0, item_q.row} >= lim;
  assign inc     = sat_inc(cnt_rd_q, 17'd1);

  // Memory ports: one write, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) cnt_mem[idx_q[RowW-1:0]] <= '0;
    else if (cmd_i.fin_wr) begin
      cnt_mem[idx_q[RowW-1:0]]   <= sum_q;
      start_mem[idx_q[RowW-1:0]] <= sum_q;
    end else if (cmd_i.finish && !row_bad &&
                 (item_q.action == ACT_COUNT || item_q.action == ACT_PLACE))
      cnt_mem[item_q.row] <= inc;
    if (cmd_i.fin_rd) cnt_rd_q <= cnt_mem[idx_q[RowW-1:0]];
    else if (cmd_i.rd_item) cnt_rd_q <= cnt_mem[item_q.row];
    if (cmd_i.rd_item) start_rd_q <= start_mem[item_q.row];
    if (cmd_i.load) item_q <= in_item_i;
  end

  // Index walk and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.clr_idx) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.clr_wr) begin
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.fin_wr) begin
      idx_q <= idx_q + 1'b1;
      sum_q <= sat_inc(sum_q, cnt_rd_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_full_q <= 1'b1;
    end else if (cmd_i.out_take) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= '0;
      case (item_q.action)
        ACT_FINALIZE: out_q.pointer <= sum_q;
        ACT_COUNT:    out_q.error <= row_bad;
        ACT_PLACE: begin
          if (row_bad) out_q.error <= 1'b1;
          else begin
            out_q.slot      <= cnt_rd_q[15:0];
            out_q.out_col   <= item_q.col;
            out_q.out_value <= item_q.value;
          end
        end
        ACT_READ: begin
          if (row_bad) out_q.error <= 1'b1;
          else out_q.pointer <= start_rd_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.action   = item_q.action;
    sts_o.out_full = out_full_q;
    sts_o.clr_last = idx_q == (RowW+1)'(MaxRows - 1);
    sts_o.idx_last = (idx_q + 1'b1) >= lim;
  end

  assign out_item_o = out_q;
endmodule

/* rtl/csct_ctrl.sv */
// Controller of the CSC transpose core: sequences clear, finalize and
// read-modify-write operations. Depends on csct_pkg.
module csct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  logic [10:0]    num_rows_i,
  input  csct_pkg::sts_t sts_i,
  output csct_pkg::cmd_t cmd_o
);
  import csct_pkg::*;

  state_e state_q, state_d;
  logic   take;
  logic   lim_zero;

  assign lim_zero = num_rows_i == 11'd0;
  assign take     = sts_i.out_full && out_ready_i;

  // Reset lands in the counter clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_INIT;
    else state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.out_take = take;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = ST_RMW;
        end
      end
      ST_RMW: begin
        unique case (sts_i.action)
          ACT_START:    state_d = ST_CLEAR;
          ACT_FINALIZE: state_d = lim_zero ? ST_RESP : ST_FIN_RD;
          default: begin
            cmd_o.rd_item = 1'b1;
            state_d       = ST_RESP;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_RESP;
      end
      ST_FIN_RD: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        cmd_o.fin_wr = 1'b1;
        state_d      = sts_i.idx_last ? ST_RESP : ST_FIN_RD;
      end
      ST_RESP: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* rtl/sparse_csc_transpose_core.sv */
// Top level of the CSC transpose core: config register, controller and
// datapath. Depends on csct_pkg, csct_ctrl, csct_datapath.
//
// Usage: items enter on in_valid/in_ready with an in_item_t payload and
// leave on out_valid/out_ready, one result item per input item. The user
// writes num_rows through cfg_valid/cfg_ready only while idle (not enforced).
// Count, place, read and unknown actions pass from accept through ST_RMW
// (memory read) and ST_RESP into the output register; start zeroes the
// counters of all 1024 rows, one write per row; finalize alternates
// ST_FIN_RD and ST_FIN_WR over the rows, capped at 1024 (a read and a write
// of the counter memory per row), or goes to ST_RESP when num_rows is zero.
// One item is in flight at a time; the next is taken once its result is ready.
// A finished result waits in the output register; the next item is accepted
// while it waits, and the controller holds before writing a new result until
// the receiver takes the old one, holding off the input meanwhile.
// Reset: num_rows returns to 1024, no result is pending, and a clearing pass
// over all 1024 counters runs with in_ready low.
module sparse_csc_transpose_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  csct_pkg::in_item_t  in_item_i,
  output logic                out_valid,
  input  logic                out_ready,
  output csct_pkg::out_item_t out_item_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_rows_i
);
  import csct_pkg::*;

  logic [10:0] num_rows_q;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_rows_q <= 11'd1024;
    else if (cfg_valid) num_rows_q <= cfg_rows_i;
  end

  csct_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_ready_i(out_ready),
    .num_rows_i (num_rows_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csct_datapath u_dp (
    .clk_i, .rst_ni,
    .in_item_i,
    .num_rows_i (num_rows_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o
  );

  assign out_valid = sts.out_full;
endmodule
